FILE: src/wcg_pkg.sv
// ----------------------------------------------------------------------------
// wcg_pkg
// Shared types, constants and the quarter-wave cosine table of the window
// coefficient generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

  localparam int IDX_W    = 16;
  localparam int LEN_W    = 17;
  localparam int COEF_W   = 17;
  localparam int DEN_W    = 33;
  localparam int QUO_W    = 17;
  localparam int DIV_STEPS = 16;
  localparam int K_W      = 12;
  localparam int COS_W    = 18;
  localparam int NUM_W    = 26;
  localparam int NN_W     = 23;
  localparam int RCP_W    = 24;
  localparam int RCP_SHIFT = 30;

  localparam logic [LEN_W-1:0]  MAX_POINTS     = 17'd65536;
  localparam logic [LEN_W-1:0]  LEN_RESET      = 17'd1024;
  localparam logic [COEF_W-1:0] COEF_ONE       = 17'd65536;
  localparam int                COS_TABLE_SIZE = 4096;
  localparam int                QTAB_LAST      = COS_TABLE_SIZE / 4;

  // floor(x/100) = (x * DIV100_MUL) >> RCP_SHIFT for x < 2^23
  localparam logic [RCP_W-1:0] DIV100_MUL = 24'd10737419;

  localparam logic signed [NUM_W-1:0] HAM_A = 26'sd3538944;
  localparam logic signed [NUM_W-1:0] HAM_B = 26'sd46;
  localparam logic signed [NUM_W-1:0] HAN_A = 26'sd3276800;
  localparam logic signed [NUM_W-1:0] HAN_B = 26'sd50;
  localparam logic signed [NUM_W-1:0] BLK_A = 26'sd2752512;
  localparam logic signed [NUM_W-1:0] BLK_B = 26'sd50;
  localparam logic signed [NUM_W-1:0] BLK_D = 26'sd8;
  localparam logic signed [NUM_W-1:0] RND_HALF = 26'sd50;

  localparam logic CFG_WINDOW_TYPE   = 1'b0;
  localparam logic CFG_WINDOW_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    WIN_RECT     = 3'd0,
    WIN_HAMMING  = 3'd1,
    WIN_HANN     = 3'd2,
    WIN_BLACKMAN = 3'd3,
    WIN_WELCH    = 3'd4,
    WIN_TRIANGLE = 3'd5
  } win_t;

  typedef struct packed {
    logic       valid;
    logic       err;
    logic [2:0] wtype;
  } side_t;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] TAYLOR_DIV [1:13] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                64'd132, 64'd182, 64'd240, 64'd306,
                                                64'd380, 64'd462, 64'd552, 64'd650};

  typedef logic [COEF_W-1:0] qtab_t [0:QTAB_LAST];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // round(65536*cos((pi/2)*j/QTAB_LAST))
  function automatic logic [COEF_W-1:0] quarter_cos(input int j);
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] c;
    num  = 64'(4 * j);
    x    = (HALF_PI_Q60 / COS_TABLE_SIZE) * num
         + ((HALF_PI_Q60 % COS_TABLE_SIZE) * num) / COS_TABLE_SIZE;
    x2   = mul_q60(x, x);
    term = 64'd1 << 60;
    pos  = term;
    neg  = 64'd0;
    for (int n = 1; n <= 13; n++) begin
      term = mul_q60(term, x2) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    c = (pos > neg) ? pos - neg : 64'd0;
    c = (c + (64'd1 << 43)) >> 44;
    return c[COEF_W-1:0];
  endfunction

  function automatic qtab_t build_qcos();
    qtab_t t;
    for (int j = 0; j <= QTAB_LAST; j++) begin
      t[j] = quarter_cos(j);
    end
    return t;
  endfunction

  localparam qtab_t QCOS = build_qcos();

  function automatic logic signed [COS_W-1:0] cos_lut(input logic [K_W-1:0] k);
    logic [K_W-3:0]    j;
    logic [K_W-2:0]    jm;
    logic [COEF_W-1:0] mag;
    j  = k[K_W-3:0];
    jm = (K_W-1)'(QTAB_LAST) - {1'b0, j};
    unique case (k[K_W-1:K_W-2])
      2'd0:    mag = QCOS[j];
      2'd1:    mag = QCOS[jm];
      2'd2:    mag = QCOS[j];
      default: mag = QCOS[jm];
    endcase
    if (k[K_W-1] ^ k[K_W-2]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage

FILE: src/wcg_div.sv
// ----------------------------------------------------------------------------
// wcg_div
// Pipelined restoring divider: q = floor((X*2^16 + H) / D) for X < D,
// one quotient bit per stage, rounding step at the end.
// ----------------------------------------------------------------------------
module wcg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wcg_pkg::side_t             in_side,
  input  logic [wcg_pkg::DEN_W-1:0]  in_num,
  input  logic [wcg_pkg::DEN_W-1:0]  in_den,
  input  logic [wcg_pkg::DEN_W-2:0]  in_half,
  output wcg_pkg::side_t             out_side,
  output logic [wcg_pkg::QUO_W-1:0]  out_quo
);
  import wcg_pkg::*;

  side_t                side_r [0:DIV_STEPS+1];
  logic [DEN_W-1:0]     rem_r  [0:DIV_STEPS];
  logic [DEN_W-1:0]     den_r  [0:DIV_STEPS];
  logic [DEN_W-2:0]     half_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r  [0:DIV_STEPS];
  logic [QUO_W-1:0]     q_r;
  logic [DEN_W:0]       fin_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
    end else begin
      side_r[0] <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= in_num;
    den_r[0]  <= in_den;
    half_r[0] <= in_half;
    quo_r[0]  <= '0;
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_r[s-1], 1'b0};
    assign ge    = trial >= {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s] <= '0;
      end else begin
        side_r[s] <= side_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? DEN_W'(trial - {1'b0, den_r[s-1]}) : DEN_W'(trial);
      den_r[s]  <= den_r[s-1];
      half_r[s] <= half_r[s-1];
      quo_r[s]  <= {quo_r[s-1][DIV_STEPS-2:0], ge};
    end
  end

  assign fin_sum = {1'b0, rem_r[DIV_STEPS]} + {2'b0, half_r[DIV_STEPS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[DIV_STEPS+1] <= '0;
    end else begin
      side_r[DIV_STEPS+1] <= side_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= {1'b0, quo_r[DIV_STEPS]}
         + QUO_W'(fin_sum >= {1'b0, den_r[DIV_STEPS]});
  end

  assign out_side = side_r[DIV_STEPS+1];
  assign out_quo  = q_r;

endmodule

FILE: src/fft_window_coefficient_generator.sv
// ----------------------------------------------------------------------------
// fft_window_coefficient_generator
// Window coefficient for a point index at the configured length and type.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_point_index and pulse start; the beat is taken on any
//   edge with start high and busy low. busy never rises, so one index can be
//   taken every cycle.
//   Output: out_valid is high for one cycle with out_coefficient (unsigned
//   Q1.16, 65536 = 1.0) and out_index_error. Results leave in input order.
//   Throughput is one per cycle. The receiver cannot stall, so there is no
//   back-pressure path.
//   Latency is 25 register stages, the first loaded at the accepting edge:
//   three front stages, the divider operand register, 16 divider stages
//   (one quotient bit each) that yield the cosine phase or the Welch/triangle
//   quotient, a rounding stage, and four stages of table lookup, weighting,
//   scaling by 1/100 and output select.
//   Config: cfg_we with cfg_addr 0 writes the window type (3 bits), 1 the
//   length (17 bits, above 65536 treated as 65536). Write only while idle.
//   Reset: type rectangle, length 1024, pipeline emptied.
// ----------------------------------------------------------------------------
module fft_window_coefficient_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [wcg_pkg::IDX_W-1:0]   in_point_index,
  output logic                        out_valid,
  output logic [wcg_pkg::COEF_W-1:0]  out_coefficient,
  output logic                        out_index_error,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [wcg_pkg::LEN_W-1:0]   cfg_wdata
);
  import wcg_pkg::*;

  logic [2:0]        wtype_r;
  logic [LEN_W-1:0]  wlen_r;

  side_t             s0_side_r;
  logic [IDX_W-1:0]  s0_idx_r;
  logic [LEN_W-1:0]  s0_n_r;

  side_t             s1_side_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [LEN_W-1:0]  s1_n_r;
  logic [LEN_W-1:0]  s1_ar_r;
  logic [LEN_W-1:0]  s1_np1_r;
  logic [DEN_W-1:0]  s1_sq_r;

  side_t             s2_side_r;
  logic [DEN_W-1:0]  s2_num_r;
  logic [DEN_W-1:0]  s2_den_r;
  logic [DEN_W-2:0]  s2_half_r;

  side_t             dv_side;
  logic [QUO_W-1:0]  dv_quo;

  side_t                    c1_side_r;
  logic [QUO_W-1:0]         c1_quo_r;
  logic signed [COS_W-1:0]  c1_cos1_r;
  logic signed [COS_W-1:0]  c1_cos2_r;

  side_t             c2_side_r;
  logic [QUO_W-1:0]  c2_quo_r;
  logic [NN_W-1:0]   c2_nn_r;
  logic              c2_pos_r;

  side_t                     c3_side_r;
  logic [QUO_W-1:0]          c3_quo_r;
  logic [NN_W+RCP_W-1:0]     c3_prod_r;
  logic                      c3_pos_r;

  logic              out_valid_r;
  logic [COEF_W-1:0] out_coef_r;
  logic              out_err_r;

  logic              accept;
  logic [LEN_W-1:0]  n_sat;
  logic signed [LEN_W+1:0] r_s;
  logic [LEN_W+1:0]  r_abs;
  logic [LEN_W-1:0]  np1;
  logic [2*LEN_W-1:0] sq_full;
  logic [2*LEN_W-1:0] ar2_full;
  logic [DEN_W-1:0]  num_nxt;
  logic [DEN_W-1:0]  den_nxt;
  logic [DEN_W-2:0]  half_nxt;
  logic [K_W-1:0]    k;
  logic signed [NUM_W-1:0] cx1;
  logic signed [NUM_W-1:0] cx2;
  logic signed [NUM_W-1:0] wnum;
  logic [COEF_W-1:0] coef_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtype_r <= WIN_RECT;
      wlen_r  <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WINDOW_TYPE:   wtype_r <= cfg_wdata[2:0];
        CFG_WINDOW_LENGTH: wlen_r  <= cfg_wdata;
        default:           wlen_r  <= wlen_r;
      endcase
    end
  end

  assign n_sat = (wlen_r > MAX_POINTS) ? MAX_POINTS : wlen_r;

  // stage 0: capture beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_side_r <= '0;
    end else begin
      s0_side_r.valid <= accept;
      s0_side_r.err   <= {1'b0, in_point_index} >= n_sat;
      s0_side_r.wtype <= wtype_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_r <= in_point_index;
    s0_n_r   <= n_sat;
  end

  // stage 1: |2i - N|, N+1, (N+1)^2
  assign r_s     = $signed({2'b0, s0_idx_r, 1'b0}) - $signed({2'b0, s0_n_r});
  assign r_abs   = r_s[LEN_W+1] ? (LEN_W+2)'(0) - r_s : r_s;
  assign np1     = s0_n_r + LEN_W'(1);
  assign sq_full = (2*LEN_W)'(np1) * (2*LEN_W)'(np1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
    end else begin
      s1_side_r <= s0_side_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= s0_idx_r;
    s1_n_r   <= s0_n_r;
    s1_ar_r  <= r_abs[LEN_W-1:0];
    s1_np1_r <= np1;
    s1_sq_r  <= sq_full[DEN_W-1:0];
  end

  // stage 2: divider operands
  assign ar2_full = (2*LEN_W)'(s1_ar_r) * (2*LEN_W)'(s1_ar_r);

  always_comb begin
    unique case (s1_side_r.wtype)
      WIN_WELCH: begin
        num_nxt  = s1_sq_r - ar2_full[DEN_W-1:0];
        den_nxt  = s1_sq_r;
        half_nxt = s1_sq_r[DEN_W-1:1];
      end
      WIN_TRIANGLE: begin
        num_nxt  = DEN_W'(s1_np1_r - s1_ar_r);
        den_nxt  = DEN_W'(s1_np1_r);
        half_nxt = (DEN_W-1)'(s1_np1_r[LEN_W-1:1]);
      end
      default: begin
        num_nxt  = DEN_W'(s1_idx_r);
        den_nxt  = DEN_W'(s1_n_r);
        half_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else begin
      s2_side_r <= s1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_num_r  <= num_nxt;
    s2_den_r  <= den_nxt;
    s2_half_r <= half_nxt;
  end

  wcg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_side  (s2_side_r),
    .in_num   (s2_num_r),
    .in_den   (s2_den_r),
    .in_half  (s2_half_r),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // cosine lookup, k = phase >> 4
  assign k = dv_quo[QUO_W-2:QUO_W-1-K_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_side_r <= '0;
    end else begin
      c1_side_r <= dv_side;
    end
  end

  always_ff @(posedge clk) begin
    c1_quo_r  <= dv_quo;
    c1_cos1_r <= cos_lut(k);
    c1_cos2_r <= cos_lut({k[K_W-2:0], 1'b0});
  end

  // weighted sum
  assign cx1 = NUM_W'(c1_cos1_r);
  assign cx2 = NUM_W'(c1_cos2_r);

  always_comb begin
    unique case (c1_side_r.wtype)
      WIN_HAMMING:  wnum = HAM_A - HAM_B * cx1;
      WIN_HANN:     wnum = HAN_A - HAN_B * cx1;
      WIN_BLACKMAN: wnum = BLK_A - BLK_B * cx1 + BLK_D * cx2;
      default:      wnum = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_side_r <= '0;
    end else begin
      c2_side_r <= c1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    c2_quo_r <= c1_quo_r;
    c2_pos_r <= wnum > 0;
    c2_nn_r  <= NN_W'(wnum + RND_HALF);
  end

  // divide by 100
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_side_r <= '0;
    end else begin
      c3_side_r <= c2_side_r;
    end
  end

  always_ff @(posedge clk) begin
    c3_quo_r  <= c2_quo_r;
    c3_pos_r  <= c2_pos_r;
    c3_prod_r <= (NN_W+RCP_W)'(c2_nn_r) * (NN_W+RCP_W)'(DIV100_MUL);
  end

  // result select
  always_comb begin
    if (c3_side_r.err) begin
      coef_nxt = '0;
    end else begin
      unique case (c3_side_r.wtype)
        WIN_HAMMING, WIN_HANN, WIN_BLACKMAN: begin
          coef_nxt = c3_pos_r ? c3_prod_r[RCP_SHIFT+COEF_W-1:RCP_SHIFT] : '0;
        end
        WIN_WELCH, WIN_TRIANGLE: coef_nxt = c3_quo_r;
        default:                 coef_nxt = COEF_ONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c3_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_coef_r <= coef_nxt;
    out_err_r  <= c3_side_r.err;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_index_error = out_err_r;

endmodule
